// ===== sv/hash_table_insert_lookup_macros.svh =====
// Assertion macros used by the hash table controller.
`ifndef HASH_TABLE_INSERT_LOOKUP_MACROS_SVH
`define HASH_TABLE_INSERT_LOOKUP_MACROS_SVH

// Same-cycle implication, sampled on clk, disabled while rst_n is low.
`define HT_ASSERT_SAME(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("hash table check failed");

// Next-cycle implication, sampled on clk, disabled while rst_n is low.
`define HT_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("hash table check failed");

`endif

// ===== sv/ht_pkg.sv =====
// Shared types, constants and codes of the hash table.
package ht_pkg;

  localparam int MAX_BUCKET_BITS_DEF = 10;
  localparam int WAYS_DEF            = 4;
  localparam int VALUE_BITS_DEF      = 32;
  localparam int MIN_BUCKET_BITS     = 4;
  localparam int CFG_BITS            = 4;
  localparam int KEY_BITS            = 64;
  localparam int IN_VALUE_BITS       = 32;
  localparam int OUT_VALUE_BITS      = 32;

  typedef enum logic [2:0] {
    ST_INSERTED  = 3'd0,
    ST_PRESENT   = 3'd1,
    ST_FOUND     = 3'd2,
    ST_NOT_FOUND = 3'd3,
    ST_FULL      = 3'd4
  } status_t;

  localparam logic CMD_PUT = 1'b0;
  localparam logic CMD_GET = 1'b1;

  typedef struct packed {
    logic                     cmd;
    logic [KEY_BITS-1:0]      key;
    logic [IN_VALUE_BITS-1:0] value;
  } in_word_t;

  typedef struct packed {
    status_t                   status;
    logic [OUT_VALUE_BITS-1:0] value_out;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic capture;
    logic clr_run;
    logic commit;
  } ht_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
  } ht_stat_t;

endpackage

// ===== sv/ht_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module ht_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                     clk,
  input  logic                                     we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                         wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== sv/ht_datapath.sv =====
// Datapath of the hash table: bucket memories, key compare, result register.
module ht_datapath
  import ht_pkg::*;
#(
  parameter int MAX_BUCKET_BITS = MAX_BUCKET_BITS_DEF,
  parameter int WAYS            = WAYS_DEF,
  parameter int VALUE_BITS      = VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  in_word_t            in_data,
  input  ht_cmd_t             cmd,
  output ht_stat_t            stat,
  output out_word_t           out_data
);

  localparam int AW    = MAX_BUCKET_BITS;
  localparam int DEPTH = 1 << AW;
  localparam int CW    = $clog2(WAYS + 1);

  logic [CFG_BITS-1:0]   bits_r;
  logic [AW-1:0]         clr_r;
  logic [AW-1:0]         mask;
  logic [AW-1:0]         in_bucket;
  logic [AW-1:0]         rd_addr;

  logic                  cmd_r;
  logic [KEY_BITS-1:0]   key_r;
  logic [VALUE_BITS-1:0] val_r;
  logic [AW-1:0]         bucket_r;

  logic [WAYS-1:0][KEY_BITS-1:0]   key_rd;
  logic [WAYS-1:0][VALUE_BITS-1:0] val_rd;
  logic [WAYS-1:0]                 lane_we;
  logic [CW-1:0]                   cnt_rd;

  logic [WAYS-1:0]       match;
  logic [WAYS-1:0]       first;
  logic [VALUE_BITS-1:0] vsel;
  logic                  hit;
  logic                  full;
  logic                  ins;
  out_word_t             res;
  out_word_t             out_r;

  logic                  cnt_we;
  logic [AW-1:0]         cnt_waddr;
  logic [CW-1:0]         cnt_wdata;

  // Configuration register and the clearing sweep address.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bits_r <= CFG_BITS'(MIN_BUCKET_BITS);
      clr_r  <= '0;
    end else if (cfg_we) begin
      bits_r <= cfg_wdata;
      clr_r  <= '0;
    end else if (cmd.clr_run) begin
      clr_r  <= clr_r + AW'(1);
    end
  end

  assign stat.clr_last = &clr_r;

  // Bits below the minimum always count; bits above the physical width cannot exist.
  always_comb begin
    for (int i = 0; i < AW; i++) begin
      mask[i] = (i < MIN_BUCKET_BITS) || (int'(bits_r) > i);
    end
  end

  assign in_bucket = in_data.key[AW-1:0] & mask;
  assign rd_addr   = cmd.capture ? in_bucket : bucket_r;

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      cmd_r    <= in_data.cmd;
      key_r    <= in_data.key;
      val_r    <= VALUE_BITS'(in_data.value);
      bucket_r <= in_bucket;
    end
  end

  // One key lane and one value lane per way, all read at the bucket address.
  for (genvar w = 0; w < WAYS; w++) begin : g_lane
    ht_ram #(.WIDTH(KEY_BITS), .DEPTH(DEPTH)) u_key_ram (
      .clk   (clk),
      .we    (lane_we[w]),
      .waddr (bucket_r),
      .wdata (key_r),
      .raddr (rd_addr),
      .rdata (key_rd[w])
    );

    ht_ram #(.WIDTH(VALUE_BITS), .DEPTH(DEPTH)) u_val_ram (
      .clk   (clk),
      .we    (lane_we[w]),
      .waddr (bucket_r),
      .wdata (val_r),
      .raddr (rd_addr),
      .rdata (val_rd[w])
    );
  end

  ht_ram #(.WIDTH(CW), .DEPTH(DEPTH)) u_cnt_ram (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (rd_addr),
    .rdata (cnt_rd)
  );

  // Compare every occupied way, keep the earliest match.
  always_comb begin
    match = '0;
    vsel  = '0;
    for (int w = 0; w < WAYS; w++) begin
      match[w] = (CW'(w) < cnt_rd) && (key_rd[w] == key_r);
    end
    first = match & (~match + WAYS'(1));
    for (int w = 0; w < WAYS; w++) begin
      if (first[w]) begin
        vsel = vsel | val_rd[w];
      end
    end
  end

  assign hit  = |match;
  assign full = (cnt_rd == CW'(WAYS));
  assign ins  = (cmd_r == CMD_PUT) && !hit && !full;

  always_comb begin
    res.value_out = '0;
    if (cmd_r == CMD_PUT) begin
      if (hit) begin
        res.status = ST_PRESENT;
      end else if (full) begin
        res.status = ST_FULL;
      end else begin
        res.status = ST_INSERTED;
      end
    end else begin
      if (hit) begin
        res.status    = ST_FOUND;
        res.value_out = OUT_VALUE_BITS'(vsel);
      end else begin
        res.status = ST_NOT_FOUND;
      end
    end
  end

  always_comb begin
    for (int w = 0; w < WAYS; w++) begin
      lane_we[w] = cmd.commit && ins && (cnt_rd == CW'(w));
    end
  end

  assign cnt_we    = cmd.clr_run || (cmd.commit && ins);
  assign cnt_waddr = cmd.clr_run ? clr_r : bucket_r;
  assign cnt_wdata = cmd.clr_run ? '0 : cnt_rd + CW'(1);

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_r <= res;
    end
  end

  assign out_data = out_r;

endmodule

// ===== sv/ht_ctrl.sv =====
// Controller of the hash table: clearing sweep, lookup sequencing, output valid.
`include "hash_table_insert_lookup_macros.svh"

module ht_ctrl
  import ht_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     cfg_we,
  input  logic     in_valid,
  input  logic     out_stall,
  input  ht_stat_t stat,
  output logic     in_stall,
  output logic     out_valid,
  output ht_cmd_t  cmd
);

  typedef enum logic [1:0] {
    S_CLEAR,
    S_IDLE,
    S_LOOK
  } state_t;

  state_t state_r;
  logic   out_valid_r;
  logic   out_free;

  assign out_free    = !out_valid_r || !out_stall;
  assign in_stall    = (state_r != S_IDLE);
  assign out_valid   = out_valid_r;

  assign cmd.capture = (state_r == S_IDLE) && in_valid;
  assign cmd.clr_run = (state_r == S_CLEAR) && !cfg_we;
  assign cmd.commit  = (state_r == S_LOOK) && out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_valid_r && !out_stall) begin
        out_valid_r <= 1'b0;
      end

      if (cfg_we) begin
        state_r <= S_CLEAR;
      end else begin
        case (state_r)
          S_CLEAR: begin
            if (stat.clr_last) begin
              state_r <= S_IDLE;
            end
          end
          S_IDLE: begin
            if (in_valid) begin
              state_r <= S_LOOK;
            end
          end
          S_LOOK: begin
            if (out_free) begin
              state_r <= S_IDLE;
            end
          end
          default: begin
            state_r <= S_CLEAR;
          end
        endcase
      end
    end
  end

  `HT_ASSERT_NEXT(a_capture_looks, cmd.capture && !cfg_we, state_r == S_LOOK)
  `HT_ASSERT_NEXT(a_look_holds, (state_r == S_LOOK) && !out_free && !cfg_we, state_r == S_LOOK)
  `HT_ASSERT_SAME(a_clear_stalls, state_r == S_CLEAR, in_stall && !cmd.capture)
  `HT_ASSERT_NEXT(a_commit_shows, cmd.commit, out_valid_r)

endmodule

// ===== sv/hash_table_insert_lookup.sv =====
// A result word is registered at the commit that follows the bucket row read of its
// accepted input word, or later while an earlier result still waits in the output register.
// A new word is accepted only after the previous one commits; the bucket row read
// of the registered-read memories and the compare and write-back are separate steps.
// Reset is synchronous; after reset and after every bucket_bits write the chain counts
// are swept to zero over all 2**MAX_BUCKET_BITS buckets while the input is stalled.
module hash_table_insert_lookup
  import ht_pkg::*;
#(
  parameter int MAX_BUCKET_BITS = MAX_BUCKET_BITS_DEF,
  parameter int WAYS            = WAYS_DEF,
  parameter int VALUE_BITS      = VALUE_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                cfg_we,
  input  logic [CFG_BITS-1:0] cfg_wdata,
  input  logic                in_valid,
  output logic                in_stall,
  input  in_word_t            in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output out_word_t           out_data
);

  // The controller sequences each word through capture, lookup and commit.
  // A word is taken only in the idle state; its bucket row is read at the
  // accepting edge, so the compare runs in the following cycle against the
  // registered memory outputs. The commit writes the new entry of an insert,
  // bumps the chain count and loads the result register at the same edge. Since
  // only one word is in flight, a following word to the same bucket always sees
  // the updated row, and no forwarding is needed.
  ht_cmd_t  ctl_cmd;
  ht_stat_t dp_stat;

  ht_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .in_valid  (in_valid),
    .out_stall (out_stall),
    .stat      (dp_stat),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .cmd       (ctl_cmd)
  );

  // The datapath holds the bucket_bits register, the per-way key and value
  // memories, the chain count memory and the result register. The result
  // register lets the next word be accepted while a finished result waits.
  ht_datapath #(
    .MAX_BUCKET_BITS (MAX_BUCKET_BITS),
    .WAYS            (WAYS),
    .VALUE_BITS      (VALUE_BITS)
  ) u_datapath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (ctl_cmd),
    .stat      (dp_stat),
    .out_data  (out_data)
  );

endmodule
